FILE: rtl/ovrq_pkg.sv
// ============================================================================
// ovrq_pkg
// Shared sizes and codes of the overwriting ring queue.
// ============================================================================
`default_nettype none

package ovrq_pkg;

    // Storage geometry
    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = 5;
    localparam int DATA_W = 32;

    // Operation codes carried on func
    typedef enum logic [0:0] {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_PUSHED      = 2'd0,
        ST_PUSHED_OVER = 2'd1,
        ST_POPPED      = 2'd2,
        ST_EMPTY       = 2'd3
    } status_t;

    // Capacity as written on reset
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

endpackage

`default_nettype wire

FILE: rtl/overwriting_ring_queue.sv
// ============================================================================
// overwriting_ring_queue
// Circular FIFO of signed 32-bit words that overwrites its oldest entry.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready, func, push_value) carries one operation
//   per transaction: a push writes push_value at the tail, a pop takes the
//   oldest word. Each transaction yields exactly one result on the output
//   channel (out_valid/out_ready, pop_value, status, fill_count).
//   The result is registered: it enters the result register on acceptance, or the
//   skid register while the result register is stalled. Throughput: one transaction
//   per cycle while in_ready is high; the whole step (slot write or read, pointer
//   wrap, count update) settles between the input handshake and the output stage.
//   A two-entry output stage (result register plus skid register) keeps
//   in_ready high while a single result waits; in_ready drops only when both
//   hold a result, i.e. after the receiver has stalled for two results.
//   cfg_we/cfg_wdata set the capacity (0 acts as 1, above 16 acts as 16) and
//   empty the queue; write it only while the block is idle.
//   Reset: capacity 16, queue empty, no result pending. The slot storage is
//   not cleared; only slots written since the queue was last emptied are read.
// ============================================================================
`default_nettype none

module overwriting_ring_queue (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // configuration
    input  wire logic                                 cfg_we,
    input  wire logic [ovrq_pkg::CNT_W-1:0]           cfg_wdata,
    // input channel
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic                                 func,
    input  wire logic signed [ovrq_pkg::DATA_W-1:0]   push_value,
    // output channel
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [ovrq_pkg::DATA_W-1:0]        pop_value,
    output logic [1:0]                                status,
    output logic [ovrq_pkg::CNT_W-1:0]                fill_count
);

    typedef struct packed {
        logic signed [ovrq_pkg::DATA_W-1:0] value;
        ovrq_pkg::status_t                  code;
        logic [ovrq_pkg::CNT_W-1:0]         count;
    } result_t;

    // Queue state
    logic [ovrq_pkg::DATA_W-1:0] slot_mem [ovrq_pkg::DEPTH];
    logic [ovrq_pkg::IDX_W-1:0]  head_reg, head_next;
    logic [ovrq_pkg::IDX_W-1:0]  tail_reg, tail_next;
    logic [ovrq_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [ovrq_pkg::CNT_W-1:0]  cap_reg, cap_next;

    // Output stages
    result_t out_reg, skid_reg, res_next;
    logic    out_valid_reg, skid_valid_reg;

    logic                        accept;
    logic                        out_free;
    logic                        is_pop;
    logic                        pop_hit;
    logic [ovrq_pkg::CNT_W-1:0]  head_inc, tail_inc;

    assign accept   = in_valid && in_ready;
    assign in_ready = !skid_valid_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign is_pop   = (func == ovrq_pkg::FUNC_POP);
    assign pop_hit  = is_pop && (count_reg != '0);

    // Clamp written capacity into 1..DEPTH
    always_comb
    begin
        if (cfg_wdata == '0)
            cap_next = ovrq_pkg::CNT_W'(1);
        else if (cfg_wdata > ovrq_pkg::CAP_RESET)
            cap_next = ovrq_pkg::CAP_RESET;
        else
            cap_next = cfg_wdata;
    end

    // Pointer increments with wrap at the capacity
    assign head_inc = ovrq_pkg::CNT_W'(head_reg) + ovrq_pkg::CNT_W'(1);
    assign tail_inc = ovrq_pkg::CNT_W'(tail_reg) + ovrq_pkg::CNT_W'(1);

    // One queue step; the popped word joins the result as it is registered
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        res_next.value = '0;
        res_next.code  = ovrq_pkg::ST_PUSHED;
        if (!is_pop)
        begin
            tail_next = (tail_inc >= cap_reg) ? '0 : tail_inc[ovrq_pkg::IDX_W-1:0];
            if (count_reg >= cap_reg)
            begin
                head_next     = (head_inc >= cap_reg) ? '0 : head_inc[ovrq_pkg::IDX_W-1:0];
                res_next.code = ovrq_pkg::ST_PUSHED_OVER;
            end
            else
            begin
                count_next = count_reg + ovrq_pkg::CNT_W'(1);
            end
        end
        else if (count_reg == '0)
        begin
            res_next.code = ovrq_pkg::ST_EMPTY;
        end
        else
        begin
            head_next      = (head_inc >= cap_reg) ? '0 : head_inc[ovrq_pkg::IDX_W-1:0];
            count_next     = count_reg - ovrq_pkg::CNT_W'(1);
            res_next.code  = ovrq_pkg::ST_POPPED;
        end
        res_next.count = count_next;
    end

    // Slot storage, written on push
    always_ff @(posedge clk)
    begin
        if (accept && !is_pop)
            slot_mem[tail_reg] <= push_value;
    end

    // Pointers, count and capacity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= ovrq_pkg::CAP_RESET;
        end
        else if (cfg_we)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= cap_next;
        end
        else if (accept)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Output register and skid stage: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output register and skid stage: payload, head slot read on a pop
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= pop_hit ? {slot_mem[head_reg], res_next.code, res_next.count}
                                   : res_next;
        end
        else if (accept)
        begin
            skid_reg <= pop_hit ? {slot_mem[head_reg], res_next.code, res_next.count}
                                : res_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pop_value  = out_reg.value;
    assign status     = out_reg.code;
    assign fill_count = out_reg.count;

endmodule

`default_nettype wire

FILE: rtl/ovrq_checker.sv
// ============================================================================
// ovrq_checker
// Port-level checks of the overwriting ring queue, bound to the top level.
// ============================================================================
`default_nettype none

module ovrq_checker (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 out_valid,
    input  wire logic                                 out_ready,
    input  wire logic signed [ovrq_pkg::DATA_W-1:0]   pop_value,
    input  wire logic [1:0]                           status,
    input  wire logic [ovrq_pkg::CNT_W-1:0]           fill_count
);

    // Count never exceeds the slot count
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fill_count <= ovrq_pkg::CNT_W'(ovrq_pkg::DEPTH))
        else $error("fill_count above depth");

    // Pop on empty reports an empty queue
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ovrq_pkg::ST_EMPTY |-> fill_count == '0)
        else $error("empty pop with nonzero count");

    // A push always leaves something held
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ovrq_pkg::ST_PUSHED || status == ovrq_pkg::ST_PUSHED_OVER)
        |-> fill_count != '0)
        else $error("push left queue empty");

    // Only a successful pop carries a value
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ovrq_pkg::ST_POPPED |-> pop_value == '0)
        else $error("pop_value nonzero without pop");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pop_value) && $stable(status)
        && $stable(fill_count))
        else $error("stalled result changed");

endmodule

bind overwriting_ring_queue ovrq_checker u_ovrq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pop_value  (pop_value),
    .status     (status),
    .fill_count (fill_count)
);

`default_nettype wire

FILE: verif/overwriting_ring_queue_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// overwriting_ring_queue_tb
// Self-checking bench for the overwriting ring queue.
// A short directed table walks empty pops, full-range values, overwrite at
// small capacities and capacity writes that empty the queue. Random phases
// follow, each at its own capacity (including 0 and values above the depth)
// and its own push/pop mix, so that the queue fills, wraps, overwrites and
// drains. Both channels idle at random. Every result is compared against the
// directed table's expected result or, where none is given, an in-bench queue model.
// ============================================================================

module overwriting_ring_queue_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1430;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_IDLE     = 17;

    typedef struct packed {
        logic signed [ovrq_pkg::DATA_W-1:0] value;
        ovrq_pkg::status_t                  st;
        logic [ovrq_pkg::CNT_W-1:0]         count;
    } queue_result_t;

    typedef enum {ROW_PUSH, ROW_POP, ROW_CAP} row_kind_t;

    typedef struct {
        row_kind_t                          kind;
        logic signed [ovrq_pkg::DATA_W-1:0] value;
        bit                                 known;
        queue_result_t                      want;
    } stim_row_t;

    // DUT connections
    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    logic [ovrq_pkg::CNT_W-1:0]         cfg_wdata;
    logic                               in_valid;
    logic                               in_ready;
    logic                               func;
    logic signed [ovrq_pkg::DATA_W-1:0] push_value;
    logic                               out_valid;
    logic                               out_ready;
    logic signed [ovrq_pkg::DATA_W-1:0] pop_value;
    logic [1:0]                         status;
    logic [ovrq_pkg::CNT_W-1:0]         fill_count;

    // Queue model state
    logic signed [ovrq_pkg::DATA_W-1:0] mirror_slots [ovrq_pkg::DEPTH];
    logic [ovrq_pkg::IDX_W-1:0]         oldest_ptr;
    logic [ovrq_pkg::IDX_W-1:0]         next_ptr;
    logic [ovrq_pkg::CNT_W-1:0]         held_count;
    logic [ovrq_pkg::CNT_W-1:0]         cap_setting;

    queue_result_t expected_results [$];
    int            mismatch_count;
    int            cycle_count;
    int            send_gap_max;
    int            recv_stall_max;

    overwriting_ring_queue u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pop_value  (pop_value),
        .status     (status),
        .fill_count (fill_count)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Pointer step with wrap at the effective capacity
    function automatic logic [ovrq_pkg::IDX_W-1:0] wrap_ptr(logic [ovrq_pkg::IDX_W-1:0] p,
                                                            int eff);
        return (int'(p) + 1 >= eff) ? '0 : p + 1'b1;
    endfunction

    // One queue operation on the model; returns the result it produces
    function automatic queue_result_t ring_step(ovrq_pkg::func_t op,
                                                logic signed [ovrq_pkg::DATA_W-1:0] v);
        int            eff;
        queue_result_t r;
        eff = (cap_setting == 0) ? 1 :
              ((int'(cap_setting) > ovrq_pkg::DEPTH) ? ovrq_pkg::DEPTH : cap_setting);
        r.value = '0;
        if (op == ovrq_pkg::FUNC_PUSH)
        begin
            mirror_slots[next_ptr] = v;
            if (int'(held_count) >= eff)
            begin
                oldest_ptr = wrap_ptr(oldest_ptr, eff);
                r.st = ovrq_pkg::ST_PUSHED_OVER;
            end
            else
            begin
                held_count = held_count + 1'b1;
                r.st = ovrq_pkg::ST_PUSHED;
            end
            next_ptr = wrap_ptr(next_ptr, eff);
        end
        else if (held_count == 0)
            r.st = ovrq_pkg::ST_EMPTY;
        else
        begin
            r.value = mirror_slots[oldest_ptr];
            oldest_ptr = wrap_ptr(oldest_ptr, eff);
            held_count = held_count - 1'b1;
            r.st = ovrq_pkg::ST_POPPED;
        end
        r.count = held_count;
        return r;
    endfunction

    function automatic stim_row_t free_row(row_kind_t k, logic signed [ovrq_pkg::DATA_W-1:0] v);
        stim_row_t row;
        row.kind  = k;
        row.value = v;
        row.known = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic stim_row_t known_row(row_kind_t k,
                                            logic signed [ovrq_pkg::DATA_W-1:0] v,
                                            logic signed [ovrq_pkg::DATA_W-1:0] pv,
                                            ovrq_pkg::status_t st,
                                            logic [ovrq_pkg::CNT_W-1:0] cnt);
        stim_row_t row;
        row.kind       = k;
        row.value      = v;
        row.known      = 1'b1;
        row.want.value = pv;
        row.want.st    = st;
        row.want.count = cnt;
        return row;
    endfunction

    // Drive one transaction; called at a falling edge, returns at one
    task automatic send_op(ovrq_pkg::func_t op, logic signed [ovrq_pkg::DATA_W-1:0] v,
                           bit known, queue_result_t want);
        int            gap;
        queue_result_t r;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        func       <= op;
        push_value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = ring_step(op, v);
        expected_results.push_back(known ? want : r);
        @(negedge clk);
    endtask

    // Capacity write once every result is back; empties the queue
    task automatic set_capacity(logic [ovrq_pkg::CNT_W-1:0] c);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(negedge clk);
        cfg_we      <= 1'b0;
        cap_setting = c;
        oldest_ptr  = '0;
        next_ptr    = '0;
        held_count  = '0;
    endtask

    // Result side: random stalls, compare against the oldest expectation
    initial
    begin
        int            stall;
        queue_result_t got;
        queue_result_t want;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = $urandom_range(0, recv_stall_max);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            got.value = pop_value;
            got.st    = ovrq_pkg::status_t'(status);
            got.count = fill_count;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result value %0h status %0d count %0d",
                         $time, got.value, got.st, got.count);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    $display({"%0t: expected value %0h status %0d count %0d, ",
                              "got value %0h status %0d count %0d"},
                             $time, want.value, want.st, want.count,
                             got.value, got.st, got.count);
                    mismatch_count++;
                end
            end
            @(negedge clk);
        end
    end

    // Stimulus
    initial
    begin
        stim_row_t                          directed_rows [$];
        logic [ovrq_pkg::CNT_W-1:0]         corner_caps [5];
        logic [ovrq_pkg::CNT_W-1:0]         cap;
        logic signed [ovrq_pkg::DATA_W-1:0] v;
        int                                 sent;
        int                                 phase;
        int                                 phase_len;
        int                                 push_pct;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        in_valid       = 1'b0;
        func           = ovrq_pkg::FUNC_PUSH;
        push_value     = '0;
        mismatch_count = 0;
        send_gap_max   = MAX_IDLE;
        recv_stall_max = MAX_IDLE;
        cap_setting    = ovrq_pkg::CAP_RESET;
        oldest_ptr     = '0;
        next_ptr       = '0;
        held_count     = '0;
        corner_caps    = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17};

        // Capacity 16 after reset: empty pop, extremes, order of removal
        directed_rows.push_back(known_row(ROW_POP, 0, 0, ovrq_pkg::ST_EMPTY, 0));
        directed_rows.push_back(known_row(ROW_PUSH, 32'h7FFF_FFFF, 0, ovrq_pkg::ST_PUSHED, 1));
        directed_rows.push_back(known_row(ROW_PUSH, 32'h8000_0000, 0, ovrq_pkg::ST_PUSHED, 2));
        directed_rows.push_back(free_row(ROW_PUSH, 32'h0000_0000));
        directed_rows.push_back(free_row(ROW_PUSH, 32'hFFFF_FFFF));
        directed_rows.push_back(known_row(ROW_POP, 0, 32'h7FFF_FFFF, ovrq_pkg::ST_POPPED, 3));
        directed_rows.push_back(known_row(ROW_POP, 0, 32'h8000_0000, ovrq_pkg::ST_POPPED, 2));
        directed_rows.push_back(free_row(ROW_POP, 0));
        directed_rows.push_back(free_row(ROW_POP, 0));
        directed_rows.push_back(known_row(ROW_POP, 0, 0, ovrq_pkg::ST_EMPTY, 0));
        // Single slot: second push overwrites
        directed_rows.push_back(free_row(ROW_CAP, 1));
        directed_rows.push_back(known_row(ROW_PUSH, 32'h5555_5555, 0, ovrq_pkg::ST_PUSHED, 1));
        directed_rows.push_back(known_row(ROW_PUSH, 32'hAAAA_AAAA, 0,
                                          ovrq_pkg::ST_PUSHED_OVER, 1));
        directed_rows.push_back(known_row(ROW_POP, 0, 32'hAAAA_AAAA, ovrq_pkg::ST_POPPED, 0));
        // Capacity zero behaves as one
        directed_rows.push_back(free_row(ROW_CAP, 0));
        directed_rows.push_back(free_row(ROW_PUSH, 1));
        directed_rows.push_back(free_row(ROW_PUSH, 2));
        // Oversized capacity write drops the held entry
        directed_rows.push_back(free_row(ROW_CAP, 31));
        directed_rows.push_back(known_row(ROW_POP, 0, 0, ovrq_pkg::ST_EMPTY, 0));
        // Two slots: wrap and overwrite
        directed_rows.push_back(free_row(ROW_CAP, 2));
        directed_rows.push_back(free_row(ROW_PUSH, 32'h1234_5678));
        directed_rows.push_back(free_row(ROW_PUSH, -2));
        directed_rows.push_back(free_row(ROW_PUSH, 32'h0000_007F));
        directed_rows.push_back(free_row(ROW_POP, 0));
        directed_rows.push_back(free_row(ROW_POP, 0));
        directed_rows.push_back(known_row(ROW_POP, 0, 0, ovrq_pkg::ST_EMPTY, 0));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CAP)
                set_capacity(directed_rows[i].value[ovrq_pkg::CNT_W-1:0]);
            else
                send_op((directed_rows[i].kind == ROW_PUSH) ? ovrq_pkg::FUNC_PUSH
                                                            : ovrq_pkg::FUNC_POP,
                        directed_rows[i].value, directed_rows[i].known,
                        directed_rows[i].want);
        end

        // Random phases, each at its own capacity, mix and idling
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            cap = (phase < 5) ? corner_caps[phase]
                              : ovrq_pkg::CNT_W'($urandom_range(0, 31));
            set_capacity(cap);
            case ($urandom_range(0, 3))
                0: push_pct = 25;
                1: push_pct = 50;
                2: push_pct = 75;
                default: push_pct = 95;
            endcase
            send_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
            recv_stall_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
            phase_len      = $urandom_range(30, 110);
            if (phase_len > RANDOM_ITEMS - sent)
                phase_len = RANDOM_ITEMS - sent;
            repeat (phase_len)
            begin
                case ($urandom_range(0, 15))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = '0;
                    3: v = '1;
                    default: v = $urandom;
                endcase
                send_op(($urandom_range(0, 99) < push_pct) ? ovrq_pkg::FUNC_PUSH
                                                           : ovrq_pkg::FUNC_POP,
                        v, 1'b0, '0);
                sent++;
            end
            phase++;
        end

        // Drain and report
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
